/* rtl/core/ppw_pkg.sv */
// Shared types, constants and arithmetic helpers for the pressure projection block.
// Used by ppw_ctrl, ppw_dp and pressure_projection_with_walls; depends on nothing.
package ppw_pkg;

    localparam int ACTION_W  = 2;
    localparam int INDEX_W   = 12;
    localparam int VAL_W     = 32;
    localparam int HIDX_W    = 24;
    localparam int SWEEP_W   = 8;
    localparam int CFG_IDX_W = 2;
    localparam int STEP_W    = 4;
    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 112;
    localparam int MUL_A_W   = 34;
    localparam int MUL_B_W   = HIDX_W + 1;
    localparam int PROD_W    = MUL_A_W + MUL_B_W;
    localparam int SUM_W     = 35;

    localparam logic [CFG_IDX_W-1:0] CFG_HALF_INV_DX   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SOLVER_SWEEPS = 2'd1;

    localparam logic [HIDX_W-1:0]  HIDX_RESET  = 24'd32768;
    localparam logic [SWEEP_W-1:0] SWEEP_RESET = 8'd35;

    // per-cell step schedule of the stencil phases
    localparam logic [STEP_W-1:0] ST_RD_C = 4'd0;
    localparam logic [STEP_W-1:0] ST_RD_R = 4'd1;
    localparam logic [STEP_W-1:0] ST_RD_L = 4'd2;
    localparam logic [STEP_W-1:0] ST_RD_T = 4'd3;
    localparam logic [STEP_W-1:0] ST_RD_B = 4'd4;
    localparam logic [STEP_W-1:0] ST_MUL1 = 4'd6;
    localparam logic [STEP_W-1:0] ST_MUL2 = 4'd7;
    localparam logic [STEP_W-1:0] ST_WR   = 4'd8;
    localparam logic [STEP_W-1:0] ST_LWR  = 4'd2;

    typedef enum logic [ACTION_W-1:0] {
        ACT_LOAD = 2'd0,
        ACT_RUN  = 2'd1,
        ACT_READ = 2'd2,
        ACT_NONE = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        PH_IO, PH_DIV, PH_CLR, PH_GS, PH_PWALL, PH_GRAD, PH_VWALL
    } phase_t;

    typedef enum logic [2:0] {
        NB_C, NB_R, NB_L, NB_T, NB_B
    } nb_t;

    typedef struct packed {
        phase_t phase;
        logic   rd_issue;
        nb_t    nb;
        logic   mul1;
        logic   mul2;
        logic   wr;
        logic   io_load;
        logic   io_read;
        logic   run_done;
        logic   p_init;
    } cmd_t;

    typedef struct packed {
        logic out_busy;
    } status_t;

    function automatic logic signed [VAL_W-1:0] sat32(input logic signed [63:0] v);
        logic signed [VAL_W-1:0] r;
        if (v > 64'sd2147483647)
            r = 32'sh7fffffff;
        else if (v < -64'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[VAL_W-1:0];
        return r;
    endfunction

    // product >> 16, round half up, saturate
    function automatic logic signed [VAL_W-1:0] scaled(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] t;
        t = p + PROD_W'(32768);
        return sat32(64'(t >>> 16));
    endfunction

    function automatic logic signed [VAL_W-1:0] quarter(input logic signed [SUM_W-1:0] s);
        logic signed [SUM_W-1:0] t;
        t = s + SUM_W'(2);
        return sat32(64'(t >>> 2));
    endfunction

endpackage

/* rtl/core/ppw_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ppw_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/core/ppw_dp.sv */
// Datapath: cell stores, neighbor capture, multiplier, update arithmetic, output beat.
// Depends on ppw_pkg and ppw_ram; driven by commands from ppw_ctrl.
module ppw_dp #(
    parameter int GRID_WIDTH  = 64,
    parameter int GRID_HEIGHT = 64
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  ppw_pkg::cmd_t                cmd,
    input  logic [$clog2(GRID_WIDTH*GRID_HEIGHT)-1:0] id,
    output ppw_pkg::status_t             status,
    input  logic [ppw_pkg::INDEX_W-1:0]  cell_index,
    input  logic [ppw_pkg::VAL_W-1:0]    vel_x,
    input  logic [ppw_pkg::VAL_W-1:0]    vel_y,
    input  logic                         wall_flag,
    input  logic [ppw_pkg::HIDX_W-1:0]   half_inv_dx,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         result_kind,
    output logic [ppw_pkg::INDEX_W-1:0]  cell_index_out,
    output logic [ppw_pkg::VAL_W-1:0]    vel_x_out,
    output logic [ppw_pkg::VAL_W-1:0]    vel_y_out,
    output logic [ppw_pkg::VAL_W-1:0]    pressure_out
);

    localparam int CELLS = GRID_WIDTH * GRID_HEIGHT;
    localparam int AW    = $clog2(CELLS);
    localparam int VW    = ppw_pkg::VAL_W;

    logic [31:0]   idx32;
    logic          in_range;
    logic [AW-1:0] idx_addr;
    logic [AW-1:0] raddr, waddr;

    logic          we_v, we_w, we_p, we_d;
    logic [VW-1:0] wd_vx, wd_vy, wd_p, wd_d;
    logic [VW-1:0] vx_q, vy_q, p_q, d_q;
    logic          w_q;

    logic          tag_v_reg;
    ppw_pkg::nb_t  tag_reg;
    ppw_pkg::phase_t tag_ph_reg;
    logic          io_ret_reg;
    logic [ppw_pkg::INDEX_W-1:0] io_idx_reg;
    logic          io_ok_reg;
    logic          p_valid_reg;

    logic                 c_wall_reg;
    logic signed [VW-1:0] c_vx_reg, c_vy_reg, c_p_reg, c_d_reg;
    logic [3:0]           nb_wall_reg;
    logic signed [VW-1:0] nb_val_reg [4];
    logic signed [VW-1:0] eff [4];

    logic signed [ppw_pkg::MUL_A_W-1:0] diff_all, diff_x, diff_y, mul_a;
    logic signed [ppw_pkg::MUL_B_W-1:0] mul_b;
    logic signed [ppw_pkg::PROD_W-1:0]  prod;
    logic signed [ppw_pkg::PROD_W-1:0]  prod1_reg, prod2_reg;
    logic signed [ppw_pkg::SUM_W-1:0]   sum_reg;
    logic signed [VW-1:0]               g1_reg, g2;
    logic signed [VW-1:0]               vx_new, vy_new, p_new;

    logic                 out_valid_reg;
    logic                 kind_reg;
    logic [ppw_pkg::INDEX_W-1:0] oidx_reg;
    logic [VW-1:0]        ovx_reg, ovy_reg, op_reg;

    assign idx32    = 32'(cell_index);
    assign in_range = idx32 < 32'(CELLS);
    assign idx_addr = idx32[AW-1:0];

    always_comb
    begin
        raddr = id;
        if (cmd.io_read)
        begin
            raddr = idx_addr;
        end
        else
        begin
            unique case (cmd.nb)
                ppw_pkg::NB_C: raddr = id;
                ppw_pkg::NB_R: raddr = id + AW'(1);
                ppw_pkg::NB_L: raddr = id - AW'(1);
                ppw_pkg::NB_T: raddr = id + AW'(GRID_WIDTH);
                ppw_pkg::NB_B: raddr = id - AW'(GRID_WIDTH);
                default:       raddr = id;
            endcase
        end
    end

    // wall neighbors read as zero velocity in the divergence, as the center elsewhere
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            if (cmd.phase == ppw_pkg::PH_DIV)
                eff[i] = nb_wall_reg[i] ? '0 : nb_val_reg[i];
            else
                eff[i] = nb_wall_reg[i] ? c_p_reg : nb_val_reg[i];
        end
    end

    assign diff_x   = ppw_pkg::MUL_A_W'(eff[0]) - ppw_pkg::MUL_A_W'(eff[1]);
    assign diff_y   = ppw_pkg::MUL_A_W'(eff[2]) - ppw_pkg::MUL_A_W'(eff[3]);
    assign diff_all = diff_x + diff_y;
    assign mul_a    = cmd.mul2 ? diff_y
                    : (cmd.phase == ppw_pkg::PH_DIV ? diff_all : diff_x);
    assign mul_b    = $signed({1'b0, half_inv_dx});
    assign prod     = mul_a * mul_b;

    assign g2    = ppw_pkg::scaled(prod2_reg);
    assign p_new = ppw_pkg::quarter(sum_reg);

    always_comb
    begin
        vx_new = ppw_pkg::sat32(64'(c_vx_reg) - 64'(g1_reg));
        vy_new = ppw_pkg::sat32(64'(c_vy_reg) - 64'(g2));
        if ((nb_wall_reg[1] && vx_new[VW-1]) || (nb_wall_reg[0] && !vx_new[VW-1] && vx_new != '0))
            vx_new = '0;
        if ((nb_wall_reg[3] && vy_new[VW-1]) || (nb_wall_reg[2] && !vy_new[VW-1] && vy_new != '0))
            vy_new = '0;
    end

    always_comb
    begin
        waddr = cmd.io_load ? idx_addr : id;
        we_w  = cmd.io_load && in_range;
        we_v  = (cmd.io_load && in_range)
              || (cmd.wr && (cmd.phase == ppw_pkg::PH_GRAD
                             || (cmd.phase == ppw_pkg::PH_VWALL && c_wall_reg)));
        we_p  = cmd.wr && (cmd.phase == ppw_pkg::PH_GS || cmd.phase == ppw_pkg::PH_CLR
                           || (cmd.phase == ppw_pkg::PH_PWALL && c_wall_reg));
        we_d  = cmd.wr && cmd.phase == ppw_pkg::PH_DIV && !c_wall_reg;
        wd_d  = g1_reg;
        wd_p  = (cmd.phase == ppw_pkg::PH_GS && !c_wall_reg) ? p_new : '0;
        if (cmd.io_load)
        begin
            wd_vx = vel_x;
            wd_vy = vel_y;
        end
        else if (cmd.phase == ppw_pkg::PH_GRAD && !c_wall_reg)
        begin
            wd_vx = vx_new;
            wd_vy = vy_new;
        end
        else
        begin
            wd_vx = '0;
            wd_vy = '0;
        end
    end

    ppw_ram #(.WIDTH(VW), .DEPTH(CELLS)) u_velx (
        .clk(clk), .we(we_v), .waddr(waddr), .wdata(wd_vx), .raddr(raddr), .rdata(vx_q));
    ppw_ram #(.WIDTH(VW), .DEPTH(CELLS)) u_vely (
        .clk(clk), .we(we_v), .waddr(waddr), .wdata(wd_vy), .raddr(raddr), .rdata(vy_q));
    ppw_ram #(.WIDTH(1), .DEPTH(CELLS)) u_wall (
        .clk(clk), .we(we_w), .waddr(waddr), .wdata(wall_flag), .raddr(raddr), .rdata(w_q));
    ppw_ram #(.WIDTH(VW), .DEPTH(CELLS)) u_pres (
        .clk(clk), .we(we_p), .waddr(waddr), .wdata(wd_p), .raddr(raddr), .rdata(p_q));
    ppw_ram #(.WIDTH(VW), .DEPTH(CELLS)) u_div (
        .clk(clk), .we(we_d), .waddr(waddr), .wdata(wd_d), .raddr(raddr), .rdata(d_q));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_v_reg     <= 1'b0;
            io_ret_reg    <= 1'b0;
            p_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            tag_v_reg  <= cmd.rd_issue;
            io_ret_reg <= cmd.io_read;
            if (cmd.p_init)
                p_valid_reg <= 1'b1;
            if (io_ret_reg || cmd.run_done)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        tag_reg    <= cmd.nb;
        tag_ph_reg <= cmd.phase;
        io_idx_reg <= cell_index;
        io_ok_reg  <= in_range;
        if (tag_v_reg)
        begin
            unique case (tag_reg)
                ppw_pkg::NB_C:
                begin
                    c_wall_reg <= w_q;
                    c_vx_reg   <= vx_q;
                    c_vy_reg   <= vy_q;
                    c_p_reg    <= p_q;
                    c_d_reg    <= d_q;
                end
                ppw_pkg::NB_R:
                begin
                    nb_wall_reg[0] <= w_q;
                    nb_val_reg[0]  <= (tag_ph_reg == ppw_pkg::PH_DIV) ? vx_q : p_q;
                end
                ppw_pkg::NB_L:
                begin
                    nb_wall_reg[1] <= w_q;
                    nb_val_reg[1]  <= (tag_ph_reg == ppw_pkg::PH_DIV) ? vx_q : p_q;
                end
                ppw_pkg::NB_T:
                begin
                    nb_wall_reg[2] <= w_q;
                    nb_val_reg[2]  <= (tag_ph_reg == ppw_pkg::PH_DIV) ? vy_q : p_q;
                end
                ppw_pkg::NB_B:
                begin
                    nb_wall_reg[3] <= w_q;
                    nb_val_reg[3]  <= (tag_ph_reg == ppw_pkg::PH_DIV) ? vy_q : p_q;
                end
                default: ;
            endcase
        end
        if (cmd.mul1)
        begin
            prod1_reg <= prod;
            sum_reg   <= ppw_pkg::SUM_W'(eff[0]) + ppw_pkg::SUM_W'(eff[1])
                       + ppw_pkg::SUM_W'(eff[2]) + ppw_pkg::SUM_W'(eff[3])
                       - ppw_pkg::SUM_W'(c_d_reg);
        end
        if (cmd.mul2)
        begin
            prod2_reg <= prod;
            g1_reg    <= ppw_pkg::scaled(prod1_reg);
        end
        if (io_ret_reg)
        begin
            kind_reg <= 1'b0;
            oidx_reg <= io_idx_reg;
            ovx_reg  <= io_ok_reg ? vx_q : '0;
            ovy_reg  <= io_ok_reg ? vy_q : '0;
            op_reg   <= (io_ok_reg && p_valid_reg) ? p_q : '0;
        end
        else if (cmd.run_done)
        begin
            kind_reg <= 1'b1;
            oidx_reg <= '0;
            ovx_reg  <= '0;
            ovy_reg  <= '0;
            op_reg   <= '0;
        end
    end

    assign status.out_busy = out_valid_reg;
    assign out_valid       = out_valid_reg;
    assign result_kind     = kind_reg;
    assign cell_index_out  = oidx_reg;
    assign vel_x_out       = ovx_reg;
    assign vel_y_out       = ovy_reg;
    assign pressure_out    = op_reg;

endmodule

/* rtl/core/ppw_ctrl.sv */
// Controller: handshake on the input side and the phase/cell/step sequencer of a run.
// Depends on ppw_pkg; drives ppw_dp through cmd_t.
module ppw_ctrl #(
    parameter int GRID_WIDTH  = 64,
    parameter int GRID_HEIGHT = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [ppw_pkg::ACTION_W-1:0]  action,
    input  logic                          out_ready,
    input  logic [ppw_pkg::SWEEP_W-1:0]   solver_sweeps,
    input  ppw_pkg::status_t              status,
    output ppw_pkg::cmd_t                 cmd,
    output logic [$clog2(GRID_WIDTH*GRID_HEIGHT)-1:0] id
);

    localparam int CELLS = GRID_WIDTH * GRID_HEIGHT;
    localparam int AW    = $clog2(CELLS);
    localparam int XW    = $clog2(GRID_WIDTH);
    localparam int YW    = $clog2(GRID_HEIGHT);
    localparam logic [XW-1:0] X_LAST   = XW'(GRID_WIDTH - 2);
    localparam logic [YW-1:0] Y_LAST   = YW'(GRID_HEIGHT - 2);
    localparam logic [AW-1:0] ID_FIRST = AW'(GRID_WIDTH + 1);
    localparam logic [AW-1:0] ID_LAST  = AW'(CELLS - 1);

    typedef enum logic [3:0] {
        S_IDLE, S_RDWAIT, S_DIV, S_CLR, S_GS, S_PWALL, S_GRAD, S_VWALL, S_DONE
    } state_t;

    state_t                       state_reg, state_next;
    logic [ppw_pkg::STEP_W-1:0]   step_reg, step_next;
    logic [XW-1:0]                x_reg, x_next;
    logic [YW-1:0]                y_reg, y_next;
    logic [AW-1:0]                id_reg, id_next;
    logic [ppw_pkg::SWEEP_W-1:0]  sweep_reg, sweep_next;
    logic                         last_int, last_lin, ready;

    assign last_int = (x_reg == X_LAST) && (y_reg == Y_LAST);
    assign last_lin = id_reg == ID_LAST;
    assign ready    = (state_reg == S_IDLE) && (!status.out_busy || out_ready);
    assign in_ready = ready;
    assign id       = id_reg;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        id_next    = id_reg;
        sweep_next = sweep_reg;
        cmd        = '0;
        cmd.phase  = ppw_pkg::PH_IO;
        cmd.nb     = ppw_pkg::NB_C;

        unique case (state_reg)
            S_DIV:   cmd.phase = ppw_pkg::PH_DIV;
            S_CLR:   cmd.phase = ppw_pkg::PH_CLR;
            S_GS:    cmd.phase = ppw_pkg::PH_GS;
            S_PWALL: cmd.phase = ppw_pkg::PH_PWALL;
            S_GRAD:  cmd.phase = ppw_pkg::PH_GRAD;
            S_VWALL: cmd.phase = ppw_pkg::PH_VWALL;
            default: cmd.phase = ppw_pkg::PH_IO;
        endcase

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && ready)
                begin
                    unique case (ppw_pkg::action_t'(action))
                        ppw_pkg::ACT_LOAD: cmd.io_load = 1'b1;
                        ppw_pkg::ACT_READ:
                        begin
                            cmd.io_read = 1'b1;
                            state_next  = S_RDWAIT;
                        end
                        ppw_pkg::ACT_RUN:
                        begin
                            state_next = S_DIV;
                            step_next  = '0;
                            x_next     = XW'(1);
                            y_next     = YW'(1);
                            id_next    = ID_FIRST;
                        end
                        default: ;
                    endcase
                end
            end
            S_RDWAIT: state_next = S_IDLE;
            S_DIV, S_GS, S_GRAD:
            begin
                unique case (step_reg)
                    ppw_pkg::ST_RD_C: begin cmd.rd_issue = 1'b1; cmd.nb = ppw_pkg::NB_C; end
                    ppw_pkg::ST_RD_R: begin cmd.rd_issue = 1'b1; cmd.nb = ppw_pkg::NB_R; end
                    ppw_pkg::ST_RD_L: begin cmd.rd_issue = 1'b1; cmd.nb = ppw_pkg::NB_L; end
                    ppw_pkg::ST_RD_T: begin cmd.rd_issue = 1'b1; cmd.nb = ppw_pkg::NB_T; end
                    ppw_pkg::ST_RD_B: begin cmd.rd_issue = 1'b1; cmd.nb = ppw_pkg::NB_B; end
                    ppw_pkg::ST_MUL1: cmd.mul1 = 1'b1;
                    ppw_pkg::ST_MUL2: cmd.mul2 = 1'b1;
                    ppw_pkg::ST_WR:   cmd.wr   = 1'b1;
                    default: ;
                endcase
                step_next = step_reg + ppw_pkg::STEP_W'(1);
                if (step_reg == ppw_pkg::ST_WR)
                begin
                    step_next = '0;
                    if (!last_int)
                    begin
                        // advance in raster order, hopping over the border columns
                        if (x_reg == X_LAST)
                        begin
                            x_next  = XW'(1);
                            y_next  = y_reg + YW'(1);
                            id_next = id_reg + AW'(3);
                        end
                        else
                        begin
                            x_next  = x_reg + XW'(1);
                            id_next = id_reg + AW'(1);
                        end
                    end
                    else
                    begin
                        x_next  = XW'(1);
                        y_next  = YW'(1);
                        id_next = ID_FIRST;
                        priority case (state_reg)
                            S_DIV:
                            begin
                                state_next = S_CLR;
                                id_next    = '0;
                            end
                            S_GS:
                            begin
                                if (sweep_reg == solver_sweeps - ppw_pkg::SWEEP_W'(1))
                                begin
                                    state_next = S_PWALL;
                                    id_next    = '0;
                                end
                                else
                                    sweep_next = sweep_reg + ppw_pkg::SWEEP_W'(1);
                            end
                            default:
                            begin
                                state_next = S_VWALL;
                                id_next    = '0;
                            end
                        endcase
                    end
                end
            end
            S_CLR:
            begin
                cmd.wr     = 1'b1;
                cmd.p_init = 1'b1;
                id_next    = id_reg + AW'(1);
                if (last_lin)
                begin
                    sweep_next = '0;
                    step_next  = '0;
                    if (solver_sweeps == '0)
                    begin
                        state_next = S_PWALL;
                        id_next    = '0;
                    end
                    else
                    begin
                        state_next = S_GS;
                        x_next     = XW'(1);
                        y_next     = YW'(1);
                        id_next    = ID_FIRST;
                    end
                end
            end
            S_PWALL, S_VWALL:
            begin
                cmd.rd_issue = step_reg == '0;
                cmd.wr       = step_reg == ppw_pkg::ST_LWR;
                step_next    = step_reg + ppw_pkg::STEP_W'(1);
                if (step_reg == ppw_pkg::ST_LWR)
                begin
                    step_next = '0;
                    id_next   = id_reg + AW'(1);
                    if (last_lin)
                    begin
                        if (state_reg == S_PWALL)
                        begin
                            state_next = S_GRAD;
                            x_next     = XW'(1);
                            y_next     = YW'(1);
                            id_next    = ID_FIRST;
                        end
                        else
                            state_next = S_DONE;
                    end
                end
            end
            S_DONE:
            begin
                cmd.run_done = 1'b1;
                state_next   = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
            x_reg     <= '0;
            y_reg     <= '0;
            id_reg    <= '0;
            sweep_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            x_reg     <= x_next;
            y_reg     <= y_next;
            id_reg    <= id_next;
            sweep_reg <= sweep_next;
        end
    end

endmodule

/* rtl/core/pressure_projection_with_walls.sv */
// Pressure projection with walls: top level, configuration registers and wiring.
// Depends on ppw_pkg, ppw_ctrl, ppw_dp (which holds the ppw_ram stores).
//
// Usage: slave beats carry one command each (tuser = action). A load writes
// velocity and wall bit of one cell, no result. A read raises m_tvalid once
// the store read and the output register are loaded, and holds the slave
// side off while the read is under way. A run returns one master beat
// (result_kind 1) once the projection is done; during it the slave side is
// not ready. A run makes a divergence pass over the interior, clears every
// pressure, makes Gauss-Seidel sweeps over the interior and a pressure wall
// pass over all cells, then a gradient pass over the interior and a velocity
// wall pass over all cells. Per interior cell, as each store has one read
// port, center and four neighbors are fetched one per cycle, a wait step lets
// the last read land, then multiply, second multiply and write back.
// The slave side takes a beat only while the output register is empty or
// being drained; a stalled receiver therefore holds off the next command.
// Reset empties the output, sets the registers to their defaults and makes
// pressure read as zero until the first run; other stores stay unset.
// cfg_we writes cfg_data into register cfg_index (0 half_inv_dx,
// 1 solver_sweeps); other indexes are dropped. Write only while idle.
module pressure_projection_with_walls #(
    parameter int GRID_WIDTH  = 64,
    parameter int GRID_HEIGHT = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // cell_index[11:0], vel_x[43:12], vel_y[75:44], wall_flag[76], zero pad
    input  logic [ppw_pkg::IN_DATA_W-1:0]     s_tdata,
    // action[1:0]
    input  logic [ppw_pkg::ACTION_W-1:0]      s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // cell_index_out[11:0], vel_x_out[43:12], vel_y_out[75:44],
    // pressure_out[107:76], zero pad
    output logic [ppw_pkg::OUT_DATA_W-1:0]    m_tdata,
    // result_kind
    output logic                              m_tuser,
    input  logic                              cfg_we,
    input  logic [ppw_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ppw_pkg::HIDX_W-1:0]        cfg_data
);

    localparam int AW = $clog2(GRID_WIDTH * GRID_HEIGHT);

    logic [ppw_pkg::HIDX_W-1:0]  half_inv_dx_reg;
    logic [ppw_pkg::SWEEP_W-1:0] solver_sweeps_reg;
    ppw_pkg::cmd_t               cmd;
    ppw_pkg::status_t            status;
    logic [AW-1:0]               id;
    logic [ppw_pkg::INDEX_W-1:0] cell_index_out;
    logic [ppw_pkg::VAL_W-1:0]   vel_x_out, vel_y_out, pressure_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_inv_dx_reg   <= ppw_pkg::HIDX_RESET;
            solver_sweeps_reg <= ppw_pkg::SWEEP_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == ppw_pkg::CFG_HALF_INV_DX)
                half_inv_dx_reg <= cfg_data;
            else if (cfg_index == ppw_pkg::CFG_SOLVER_SWEEPS)
                solver_sweeps_reg <= cfg_data[ppw_pkg::SWEEP_W-1:0];
        end
    end

    ppw_ctrl #(.GRID_WIDTH(GRID_WIDTH), .GRID_HEIGHT(GRID_HEIGHT)) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .action        (s_tuser),
        .out_ready     (m_tready),
        .solver_sweeps (solver_sweeps_reg),
        .status        (status),
        .cmd           (cmd),
        .id            (id)
    );

    ppw_dp #(.GRID_WIDTH(GRID_WIDTH), .GRID_HEIGHT(GRID_HEIGHT)) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .id             (id),
        .status         (status),
        .cell_index     (s_tdata[11:0]),
        .vel_x          (s_tdata[43:12]),
        .vel_y          (s_tdata[75:44]),
        .wall_flag      (s_tdata[76]),
        .half_inv_dx    (half_inv_dx_reg),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .result_kind    (m_tuser),
        .cell_index_out (cell_index_out),
        .vel_x_out      (vel_x_out),
        .vel_y_out      (vel_y_out),
        .pressure_out   (pressure_out)
    );

    assign m_tdata = {4'b0, pressure_out, vel_y_out, vel_x_out, cell_index_out};

endmodule

/* bench/testbench.sv */
// Self-checking bench for pressure_projection_with_walls: loads the whole grid,
// runs projections and reads cells back, comparing against an in-bench predictor.
// Depends on ppw_pkg and the block's RTL only.
module testbench;

    localparam int W     = 64;
    localparam int H     = 64;
    localparam int CELLS = W * H;
    localparam logic [ppw_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct {
        logic        kind;
        logic [11:0] idx;
        int          vx;
        int          vy;
        int          pr;
    } cell_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [ppw_pkg::IN_DATA_W-1:0] s_tdata = '0;
    logic [ppw_pkg::ACTION_W-1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [ppw_pkg::OUT_DATA_W-1:0] m_tdata;
    logic m_tuser;
    logic cfg_we = 1'b0;
    logic [ppw_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [ppw_pkg::HIDX_W-1:0] cfg_data = '0;

    // predictor state
    int grid_vx[CELLS];
    int grid_vy[CELLS];
    int grid_pr[CELLS];
    int grid_div[CELLS];
    bit grid_wall[CELLS];
    logic [ppw_pkg::HIDX_W-1:0] half_inv_dx = ppw_pkg::HIDX_RESET;
    logic [ppw_pkg::SWEEP_W-1:0] sweeps = ppw_pkg::SWEEP_RESET;

    cell_result_t pending_results[$];
    int mismatches = 0;
    bit idle_on = 1'b1;
    int stall_req = 0;

    pressure_projection_with_walls #(.GRID_WIDTH(W), .GRID_HEIGHT(H)) i_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic int sat(longint v);
        if (v > 64'sd2147483647)
            return 32'sh7fffffff;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return int'(v);
    endfunction

    function automatic longint round_sh(longint v, int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic int scale_hidx(longint d);
        return sat(round_sh(d * longint'(half_inv_dx), 16));
    endfunction

    function automatic void project_grid();
        int id;
        longint c, r, l, t, b, s;
        int vx, vy;
        for (int i = 0; i < CELLS; i++)
            grid_div[i] = 0;
        for (int y = 1; y < H - 1; y++)
            for (int x = 1; x < W - 1; x++)
            begin
                id = x + y * W;
                if (!grid_wall[id])
                begin
                    r = grid_wall[id + 1] ? 0 : grid_vx[id + 1];
                    l = grid_wall[id - 1] ? 0 : grid_vx[id - 1];
                    t = grid_wall[id + W] ? 0 : grid_vy[id + W];
                    b = grid_wall[id - W] ? 0 : grid_vy[id - W];
                    grid_div[id] = scale_hidx(r - l + t - b);
                end
            end
        for (int i = 0; i < CELLS; i++)
            grid_pr[i] = 0;
        for (int it = 0; it < int'(sweeps); it++)
            for (int y = 1; y < H - 1; y++)
                for (int x = 1; x < W - 1; x++)
                begin
                    id = x + y * W;
                    if (grid_wall[id])
                        grid_pr[id] = 0;
                    else
                    begin
                        c = grid_pr[id];
                        s = (grid_wall[id + 1] ? c : longint'(grid_pr[id + 1]))
                          + (grid_wall[id - 1] ? c : longint'(grid_pr[id - 1]))
                          + (grid_wall[id + W] ? c : longint'(grid_pr[id + W]))
                          + (grid_wall[id - W] ? c : longint'(grid_pr[id - W]))
                          - longint'(grid_div[id]);
                        grid_pr[id] = sat(round_sh(s, 2));
                    end
                end
        for (int i = 0; i < CELLS; i++)
            if (grid_wall[i])
                grid_pr[i] = 0;
        for (int y = 1; y < H - 1; y++)
            for (int x = 1; x < W - 1; x++)
            begin
                id = x + y * W;
                if (grid_wall[id])
                begin
                    grid_vx[id] = 0;
                    grid_vy[id] = 0;
                end
                else
                begin
                    c = grid_pr[id];
                    r = grid_wall[id + 1] ? c : grid_pr[id + 1];
                    l = grid_wall[id - 1] ? c : grid_pr[id - 1];
                    t = grid_wall[id + W] ? c : grid_pr[id + W];
                    b = grid_wall[id - W] ? c : grid_pr[id - W];
                    vx = sat(longint'(grid_vx[id]) - scale_hidx(r - l));
                    vy = sat(longint'(grid_vy[id]) - scale_hidx(t - b));
                    if (grid_wall[id - 1] && vx < 0) vx = 0;
                    if (grid_wall[id + 1] && vx > 0) vx = 0;
                    if (grid_wall[id - W] && vy < 0) vy = 0;
                    if (grid_wall[id + W] && vy > 0) vy = 0;
                    grid_vx[id] = vx;
                    grid_vy[id] = vy;
                end
            end
        for (int i = 0; i < CELLS; i++)
            if (grid_wall[i])
            begin
                grid_vx[i] = 0;
                grid_vy[i] = 0;
            end
    endfunction

    function automatic void apply_command(ppw_pkg::action_t act, logic [11:0] idx, int vx,
                                          int vy, logic wall);
        cell_result_t res;
        case (act)
            ppw_pkg::ACT_LOAD:
            begin
                grid_vx[idx] = vx;
                grid_vy[idx] = vy;
                grid_wall[idx] = wall;
            end
            ppw_pkg::ACT_RUN:
            begin
                project_grid();
                res = '{1'b1, 12'd0, 0, 0, 0};
                pending_results.push_back(res);
            end
            ppw_pkg::ACT_READ:
            begin
                res = '{1'b0, idx, grid_vx[idx], grid_vy[idx], grid_pr[idx]};
                pending_results.push_back(res);
            end
            default: ;
        endcase
    endfunction

    // leave tvalid high after the beat; the next command or stop_sending decides
    task automatic send_cmd(ppw_pkg::action_t act, logic [11:0] idx, int vx = 0, int vy = 0,
                            logic wall = 1'b0);
        if (idle_on && $urandom_range(0, 7) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= act;
        s_tdata <= {3'b0, wall, vy, vx, idx};
        do
            @(posedge clk);
        while (!s_tready);
        apply_command(act, idx, vx, vy, wall);
    endtask

    task automatic stop_sending();
        s_tvalid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_drain();
        while (pending_results.size() != 0)
            @(posedge clk);
        // loads leave no result; let the last one settle
        repeat (10) @(posedge clk);
    endtask

    task automatic write_reg(logic [ppw_pkg::CFG_IDX_W-1:0] idx,
                             logic [ppw_pkg::HIDX_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == ppw_pkg::CFG_HALF_INV_DX)
            half_inv_dx = val;
        else if (idx == ppw_pkg::CFG_SOLVER_SWEEPS)
            sweeps = val[ppw_pkg::SWEEP_W-1:0];
        @(posedge clk);
    endtask

    task automatic reconfigure(logic [ppw_pkg::HIDX_W-1:0] hidx,
                               logic [ppw_pkg::SWEEP_W-1:0] n);
        stop_sending();
        wait_drain();
        write_reg(ppw_pkg::CFG_HALF_INV_DX, hidx);
        write_reg(ppw_pkg::CFG_SOLVER_SWEEPS, {16'd0, n});
    endtask

    function automatic int rand_vel();
        if ($urandom_range(0, 7) == 0)
            return int'($urandom);
        return int'($urandom_range(0, 2097151)) - 1048576;
    endfunction

    task automatic load_random_cell(logic [11:0] idx);
        send_cmd(ppw_pkg::ACT_LOAD, idx, rand_vel(), rand_vel(), $urandom_range(0, 6) == 0);
    endtask

    task automatic test_register_extremes();
        write_reg(ppw_pkg::CFG_HALF_INV_DX, 24'hffffff);
        write_reg(ppw_pkg::CFG_SOLVER_SWEEPS, 24'd255);
        write_reg(CFG_UNUSED, 24'h5a5a5a);
        write_reg(ppw_pkg::CFG_HALF_INV_DX, 24'd0);
    endtask

    task automatic test_grid_load();
        // corner extremes first, then fill every cell so no read touches an unset entry, then interior extremes
        send_cmd(ppw_pkg::ACT_LOAD, 12'd0, 32'sh7fffffff, 32'sh80000000, 1'b1);
        send_cmd(ppw_pkg::ACT_LOAD, 12'd4095, 32'sh80000000, 32'sh7fffffff, 1'b0);
        for (int i = 1; i < CELLS - 1; i++)
            load_random_cell(i[11:0]);
        send_cmd(ppw_pkg::ACT_LOAD, 12'd65, 32'sh7fffffff, 32'sh7fffffff, 1'b0);
        send_cmd(ppw_pkg::ACT_LOAD, 12'd66, 32'sh80000000, 32'sh80000000, 1'b0);
        send_cmd(ppw_pkg::ACT_LOAD, 12'd130, 32'sh12345678, -32'sh1234, 1'b1);
    endtask

    task automatic test_directed_reads();
        send_cmd(ppw_pkg::ACT_READ, 12'd0);
        send_cmd(ppw_pkg::ACT_READ, 12'd4095);
        send_cmd(ppw_pkg::ACT_NONE, 12'd7, 32'h0f0f0f0f, 32'hf0f0f0f0, 1'b1);
        send_cmd(ppw_pkg::ACT_READ, 12'd65);
        send_cmd(ppw_pkg::ACT_READ, 12'd130);
    endtask

    task automatic test_runs_at_extremes();
        // zero sweeps with the steepest scale, then a zero scale
        reconfigure(24'hffffff, 8'd0);
        send_cmd(ppw_pkg::ACT_RUN, 12'd0);
        for (int i = 0; i < 8; i++)
            send_cmd(ppw_pkg::ACT_READ, 12'($urandom_range(0, CELLS - 1)));
        send_cmd(ppw_pkg::ACT_READ, 12'd65);
        send_cmd(ppw_pkg::ACT_READ, 12'd66);
        reconfigure(24'd0, 8'd1);
        send_cmd(ppw_pkg::ACT_RUN, 12'hfff);
        send_cmd(ppw_pkg::ACT_READ, 12'd66);
    endtask

    task automatic test_output_backpressure();
        stop_sending();
        wait_drain();
        idle_on = 1'b0;
        stall_req = 400;
        for (int i = 0; i < 30; i++)
            send_cmd(ppw_pkg::ACT_READ, 12'($urandom_range(0, CELLS - 1)));
        idle_on = 1'b1;
    endtask

    task automatic random_phase(int count, logic [ppw_pkg::SWEEP_W-1:0] n);
        int pick;
        reconfigure(24'($urandom_range(1024, 200000)), n);
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 19);
            if (pick < 9)
                load_random_cell(12'($urandom));
            else if (pick < 19)
                send_cmd(ppw_pkg::ACT_READ, 12'($urandom));
            else
                send_cmd(ppw_pkg::ACT_NONE, 12'($urandom), int'($urandom), int'($urandom),
                         1'($urandom));
        end
        send_cmd(ppw_pkg::ACT_RUN, 12'($urandom));
        for (int i = 0; i < 100; i++)
            send_cmd(ppw_pkg::ACT_READ, 12'($urandom));
    endtask

    task automatic test_final_no_idle();
        idle_on = 1'b0;
        for (int i = 0; i < 300; i++)
            if ($urandom_range(0, 1) == 0)
                load_random_cell(12'($urandom));
            else
                send_cmd(ppw_pkg::ACT_READ, 12'($urandom));
        stop_sending();
    endtask

    // result receiver: random stalls plus one long hold-off on request
    initial
    begin
        @(posedge rst_n);
        @(posedge clk);
        m_tready <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (stall_req > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall_req) @(posedge clk);
                stall_req = 0;
                m_tready <= 1'b1;
            end
            else if (idle_on && $urandom_range(0, 9) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        cell_result_t e;
        if (m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: kind %0d data %h", m_tuser, m_tdata);
            end
            else
            begin
                e = pending_results.pop_front();
                if (m_tuser !== e.kind || m_tdata[11:0] !== e.idx
                    || m_tdata[43:12] !== e.vx || m_tdata[75:44] !== e.vy
                    || m_tdata[107:76] !== e.pr)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: exp kind %0d idx %0d vx %h vy %h p %h",
                                  " / got kind %0d idx %0d vx %h vy %h p %h"},
                                 e.kind, e.idx, e.vx, e.vy, e.pr, m_tuser, m_tdata[11:0],
                                 m_tdata[43:12], m_tdata[75:44], m_tdata[107:76]);
                end
            end
        end
    end

    initial
    begin
        #24000000;
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        test_register_extremes();
        test_grid_load();
        test_directed_reads();
        test_runs_at_extremes();
        test_output_backpressure();
        random_phase(700, 8'd2);
        random_phase(400, 8'd1);
        test_final_no_idle();
        wait_drain();
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
